// File: rtl/rbof_pkg.sv
package rbof_pkg;

   // Store geometry is fixed by the 4-bit positions, index and count fields.
   localparam int DEPTH               = 16;
   localparam int POS_WIDTH           = $clog2(DEPTH);
   localparam int MOD_WIDTH           = 5;
   localparam int INDEX_WIDTH         = 4;
   localparam int COUNT_WIDTH         = 4;
   localparam int DEFAULT_ENTRY_WIDTH = 32;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(DEPTH);

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_STATUS  = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_ENTRIES_IN_USE = 1'b0,
      CSR_UNMAPPED       = 1'b1
   } csr_index_type;

   function automatic logic [POS_WIDTH-1:0] ring_next(input logic [POS_WIDTH-1:0] pos,
                                                      input logic [MOD_WIDTH-1:0] modulus);
      logic [MOD_WIDTH-1:0] n;
      n = MOD_WIDTH'(pos) + MOD_WIDTH'(1);
      if (n >= modulus) begin
         n = n - modulus;
      end
      return n[POS_WIDTH-1:0];
   endfunction

   // Out-of-range moduli are pulled back into 1..DEPTH.
   function automatic logic [MOD_WIDTH-1:0] clamp_modulus(input logic [MOD_WIDTH-1:0] v);
      logic [MOD_WIDTH-1:0] r;
      r = v;
      if (v == '0) begin
         r = MOD_WIDTH'(1);
      end else if (v > MOD_WIDTH'(DEPTH)) begin
         r = MOD_WIDTH'(DEPTH);
      end
      return r;
   endfunction

endpackage

// File: rtl/rbof_req_if.sv
interface rbof_req_if import rbof_pkg::*; #(
   parameter int ENTRY_WIDTH = DEFAULT_ENTRY_WIDTH
) ();
   logic                   valid;
   logic                   ready;
   op_type                 operation;
   logic                   overwrite;
   logic [ENTRY_WIDTH-1:0] data_in;
   logic [INDEX_WIDTH-1:0] index;

   modport source (output valid, operation, overwrite, data_in, index, input ready);
   modport sink   (input valid, operation, overwrite, data_in, index, output ready);
endinterface

// File: rtl/rbof_rsp_if.sv
interface rbof_rsp_if import rbof_pkg::*; #(
   parameter int ENTRY_WIDTH = DEFAULT_ENTRY_WIDTH
) ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [ENTRY_WIDTH-1:0] data_out;
   logic                   empty_res;
   logic                   full_res;
   logic [COUNT_WIDTH-1:0] count;

   modport source (output valid, ok, data_out, empty_res, full_res, count, input ready);
   modport sink   (input valid, ok, data_out, empty_res, full_res, count, output ready);
endinterface

// File: rtl/ring_buffer_overwrite_fifo_unit.sv
// Circular FIFO over a store of 16 entries with optional overwrite of the oldest entry; one
// slot is always kept free, so the ring holds at most entries_in_use minus one entries. Each
// request (enqueue, dequeue, peek, status) gives exactly one response carrying ok, the entry
// read and the occupancy after the operation. A request is captured in an input register and
// resolved against the ring state into the response register, so one request is taken every
// clock while the response side keeps up; a request waits in the input register while the
// response register holds a response not yet taken. The store is a register array with a
// per-entry valid bit cleared by reset, so unwritten entries read as zero. Writing
// entries_in_use (APB, offset 0x0) sets the ring modulus, clamped to 1..16, and empties the
// ring without touching the stored entries; only write it while the block is idle.
module ring_buffer_overwrite_fifo_unit import rbof_pkg::*; #(
   parameter int ENTRY_WIDTH = DEFAULT_ENTRY_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   rbof_req_if.sink                  req,
   rbof_rsp_if.source                rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   // configuration
   logic [MOD_WIDTH-1:0]   modulus_ff, modulus_in;
   csr_index_type          csr_index;
   logic                   csr_write;

   // ring state
   logic [POS_WIDTH-1:0]   rd_pos_ff, rd_pos_in;
   logic [POS_WIDTH-1:0]   wr_pos_ff, wr_pos_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [ENTRY_WIDTH-1:0] store_ff [DEPTH];
   logic [DEPTH-1:0]       entry_valid_ff;

   // input stage
   logic                   in_valid_ff, in_valid_in;
   op_type                 in_op_ff;
   logic                   in_ovw_ff;
   logic [ENTRY_WIDTH-1:0] in_data_ff;
   logic [INDEX_WIDTH-1:0] in_index_ff;

   // response stage
   logic                   out_valid_ff, out_valid_in;
   logic                   out_ok_ff;
   logic [ENTRY_WIDTH-1:0] out_data_ff;
   logic                   out_empty_ff;
   logic                   out_full_ff;
   logic [COUNT_WIDTH-1:0] out_count_ff;

   logic                   advance;
   logic                   req_take;
   logic                   full_cur;
   logic                   empty_cur;
   logic                   op_ok;
   logic                   wr_en;
   logic                   rd_en;
   logic [POS_WIDTH-1:0]   rd_addr;
   logic [MOD_WIDTH-1:0]   peek_slot;
   logic [ENTRY_WIDTH-1:0] rd_data;
   logic                   empty_next;
   logic                   full_next;

   // APB
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         CSR_ENTRIES_IN_USE: csr_prdata = CSR_DATA_WIDTH'(modulus_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_write && csr_index == CSR_ENTRIES_IN_USE) begin
         modulus_in = clamp_modulus(csr_pwdata[MOD_WIDTH-1:0]);
      end
   end

   // handshake
   assign advance      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready    = !in_valid_ff || advance;
   assign req_take     = req.valid && req.ready;
   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   // operation
   assign full_cur  = ring_next(wr_pos_ff, modulus_ff) == rd_pos_ff;
   assign empty_cur = rd_pos_ff == wr_pos_ff;

   always_comb begin
      rd_pos_in = rd_pos_ff;
      wr_pos_in = wr_pos_ff;
      count_in  = count_ff;
      op_ok     = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = rd_pos_ff;
      peek_slot = MOD_WIDTH'(rd_pos_ff) + MOD_WIDTH'(in_index_ff);
      if (peek_slot >= modulus_ff) begin
         peek_slot = peek_slot - modulus_ff;
      end
      case (in_op_ff)
         OP_ENQUEUE: begin
            if (full_cur && in_ovw_ff) begin
               // drop the oldest entry, occupancy unchanged
               rd_pos_in = ring_next(rd_pos_ff, modulus_ff);
               wr_pos_in = ring_next(wr_pos_ff, modulus_ff);
               wr_en     = 1'b1;
               op_ok     = 1'b1;
            end else if (!full_cur) begin
               wr_pos_in = ring_next(wr_pos_ff, modulus_ff);
               count_in  = count_ff + COUNT_WIDTH'(1);
               wr_en     = 1'b1;
               op_ok     = 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (!empty_cur) begin
               rd_pos_in = ring_next(rd_pos_ff, modulus_ff);
               count_in  = count_ff - COUNT_WIDTH'(1);
               rd_en     = 1'b1;
               op_ok     = 1'b1;
            end
         end
         OP_PEEK: begin
            if (MOD_WIDTH'(in_index_ff) < modulus_ff) begin
               rd_addr = peek_slot[POS_WIDTH-1:0];
               rd_en   = 1'b1;
               op_ok   = 1'b1;
            end
         end
         OP_STATUS: begin
            op_ok = 1'b1;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   assign rd_data    = (rd_en && entry_valid_ff[rd_addr]) ? store_ff[rd_addr] : '0;
   assign empty_next = rd_pos_in == wr_pos_in;
   assign full_next  = ring_next(wr_pos_in, modulus_ff) == rd_pos_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= MOD_RESET;
         rd_pos_ff      <= '0;
         wr_pos_ff      <= '0;
         count_ff       <= '0;
         entry_valid_ff <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write && csr_index == CSR_ENTRIES_IN_USE) begin
            rd_pos_ff <= '0;
            wr_pos_ff <= '0;
            count_ff  <= '0;
         end else if (advance) begin
            rd_pos_ff <= rd_pos_in;
            wr_pos_ff <= wr_pos_in;
            count_ff  <= count_in;
         end
         if (advance && wr_en) begin
            entry_valid_ff[wr_pos_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         store_ff[wr_pos_ff] <= in_data_ff;
      end
      if (req_take) begin
         in_op_ff    <= req.operation;
         in_ovw_ff   <= req.overwrite;
         in_data_ff  <= req.data_in;
         in_index_ff <= req.index;
      end
      if (advance) begin
         out_ok_ff    <= op_ok;
         out_data_ff  <= rd_data;
         out_empty_ff <= empty_next;
         out_full_ff  <= full_next;
         out_count_ff <= count_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.ok        = out_ok_ff;
   assign rsp.data_out  = out_data_ff;
   assign rsp.empty_res = out_empty_ff;
   assign rsp.full_res  = out_full_ff;
   assign rsp.count     = out_count_ff;

endmodule
